@@ rtl/core/reliable_datagram_peer_engine_core_defines.svh @@
// Assertion macros shared by the peer engine modules.
`ifndef RELIABLE_DATAGRAM_PEER_ENGINE_CORE_DEFINES_SVH
`define RELIABLE_DATAGRAM_PEER_ENGINE_CORE_DEFINES_SVH

// Condition implies consequence in the same cycle.
`define RDPE_ASSERT_NOW(label, clk, rst, cond, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error("rdpe check failed");

// Condition implies consequence in the next cycle.
`define RDPE_ASSERT_NEXT(label, clk, rst, cond, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error("rdpe check failed");

`endif

@@ rtl/core/rdpe_pkg.sv @@
// Types, codes and helper functions of the peer engine.
`timescale 1ns / 1ps
package rdpe_pkg;

  localparam logic [31:0] ALL_ONES = 32'hffff_ffff;

  localparam logic [1:0] OP_SEND   = 2'd0;
  localparam logic [1:0] OP_RECV   = 2'd1;
  localparam logic [1:0] OP_TICK   = 2'd2;
  localparam logic [1:0] OP_HANGUP = 2'd3;

  localparam logic [2:0] K_DATA    = 3'd0;
  localparam logic [2:0] K_ACK     = 3'd1;
  localparam logic [2:0] K_HANGUP  = 3'd2;
  localparam logic [2:0] K_RETX    = 3'd3;
  localparam logic [2:0] K_RESET   = 3'd4;
  localparam logic [2:0] K_DELIVER = 3'd5;
  localparam logic [2:0] K_DISCARD = 3'd6;

  localparam logic [1:0] REG_RETX_BASE = 2'd0;
  localparam logic [1:0] REG_TICK      = 2'd1;
  localparam logic [1:0] REG_MAX_TX    = 2'd2;
  localparam logic [1:0] REG_MAX_UNACK = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_STEP,
    ST_FIN,
    ST_SEND
  } state_t;

  typedef struct packed {
    logic cap;
    logic step;
    logic fin;
    logic pop;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic at_last;
  } status_t;

  // Peer state together with the results of the step that produced it.
  typedef struct packed {
    logic [31:0]       ss;
    logic [31:0]       sg;
    logic [31:0]       rs;
    logic [31:0]       rg;
    logic [31:0]       asent;
    logic [31:0]       ar;
    logic [31:0]       el;
    logic [7:0]        tc;
    logic              gl;
    logic              did_reset;
    logic              ack_ok;
    logic [1:0]        n;
    logic [2:0][2:0]   kind;
    logic [2:0][31:0]  seq;
    logic [2:0][31:0]  gen;
    logic [2:0][31:0]  ack;
    logic [2:0][31:0]  agen;
  } step_t;

  // Sequence numbers skip zero.
  function automatic logic [31:0] next_seq(input logic [31:0] a);
    return (a == ALL_ONES) ? 32'd1 : a + 32'd1;
  endfunction

  function automatic logic in_window(input logic [31:0] a, input logic [31:0] s,
                                     input logic [31:0] e);
    if (s <= e) begin
      return (a > s) && (a <= e);
    end
    return (a > s) || (a <= e);
  endfunction

  function automatic step_t f_emit(input step_t s, input logic [2:0] k,
                                   input logic [31:0] a, input logic [31:0] b,
                                   input logic [31:0] c, input logic [31:0] d);
    step_t r;
    r = s;
    if (s.n != 2'd3) begin
      r.kind[s.n] = k;
      r.seq[s.n]  = a;
      r.gen[s.n]  = b;
      r.ack[s.n]  = c;
      r.agen[s.n] = d;
      r.n         = s.n + 2'd1;
    end
    return r;
  endfunction

  function automatic step_t f_reset(input step_t s, input logic [31:0] fresh);
    step_t r;
    r = f_emit(s, K_RESET, '0, '0, '0, '0);
    r.rg        = '0;
    r.rs        = '0;
    r.asent     = '0;
    r.sg        = fresh;
    r.ss        = '0;
    r.ar        = '0;
    r.tc        = '0;
    r.el        = '0;
    r.did_reset = 1'b1;
    return r;
  endfunction

  function automatic step_t f_forget(input step_t s, input logic [31:0] fresh);
    step_t r;
    r    = f_reset(s, fresh);
    r.sg = '0;
    r.gl = 1'b0;
    return r;
  endfunction

  function automatic step_t f_ack(input step_t s, input logic hangup);
    step_t r;
    r = f_emit(s, hangup ? K_HANGUP : K_ACK, '0, hangup ? ALL_ONES : s.sg, s.rs, s.rg);
    if (s.asent < s.rs) begin
      r.asent = s.rs;
    end
    return r;
  endfunction

  function automatic step_t f_resend(input step_t s, input logic [31:0] fresh,
                                     input logic [7:0] max_tx);
    step_t r;
    r    = s;
    r.el = '0;
    if (s.tc != 8'hff) begin
      r.tc = s.tc + 8'd1;
    end
    if (s.tc > max_tx) begin
      r = f_reset(r, fresh);
    end else begin
      r = f_emit(r, K_RETX, next_seq(s.ar), s.sg, '0, '0);
    end
    return r;
  endfunction

endpackage

@@ rtl/core/rdpe_ctrl.sv @@
// Controller state machine sequencing capture, step, flag update and result transfers.
`timescale 1ns / 1ps
`include "reliable_datagram_peer_engine_core_defines.svh"
module rdpe_ctrl
  import rdpe_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    s_tvalid,
  output logic    s_tready,
  output logic    m_tvalid,
  input  logic    m_tready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) state_next = ST_LOAD;
      end
      ST_LOAD: state_next = ST_STEP;
      ST_STEP: state_next = ST_FIN;
      ST_FIN: begin
        state_next = status.empty ? ST_IDLE : ST_SEND;
      end
      ST_SEND: begin
        if (m_tready && status.at_last) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready = 1'b0;
    m_tvalid = 1'b0;
    cmd      = '0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        cmd.cap  = s_tvalid;
      end
      ST_LOAD: begin
      end
      ST_STEP: cmd.step = 1'b1;
      ST_FIN:  cmd.fin = 1'b1;
      ST_SEND: begin
        m_tvalid = 1'b1;
        cmd.pop  = m_tready;
      end
      default: begin
      end
    endcase
  end

  `RDPE_ASSERT_NEXT(a_accept_loads, clk, rst, s_tvalid && s_tready, state == ST_LOAD)
  `RDPE_ASSERT_NEXT(a_step_then_fin, clk, rst, state == ST_STEP, state == ST_FIN)
  `RDPE_ASSERT_NEXT(a_more_results, clk, rst, m_tvalid && m_tready && !status.at_last,
                    m_tvalid && !s_tready)

endmodule

@@ rtl/core/rdpe_dp.sv @@
// Datapath: configuration registers, peer state, step logic and result buffer.
`timescale 1ns / 1ps
`include "reliable_datagram_peer_engine_core_defines.svh"
module rdpe_dp
  import rdpe_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  cmd_t         cmd,
  output status_t      status,
  input  logic [167:0] s_tdata,
  input  logic [1:0]   s_tuser,
  output logic [151:0] m_tdata,
  output logic [2:0]   m_tuser,
  output logic         m_tlast,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata
);

  logic [15:0] retx_base;
  logic [15:0] tick_ms;
  logic [7:0]  max_tx;
  logic [15:0] max_unack;

  logic [1:0]  q_op;
  logic [31:0] q_seq;
  logic [31:0] q_sgen;
  logic [31:0] q_ack;
  logic [31:0] q_agen;
  logic        q_full;
  logic [31:0] q_fresh;

  step_t       cur;
  step_t       cur_next;
  logic [23:0] prod;
  logic        waiting;
  logic        waiting_next;
  logic [15:0] unacked;
  logic [15:0] unacked_next;
  logic        blocked;
  logic        resume;
  logic        resume_next;
  logic [1:0]  idx;

  logic        was_empty;
  logic        moved;
  logic [2:0]  verdict;
  logic [32:0] el_sum;
  logic [31:0] span;

  always_ff @(posedge clk) begin
    if (rst) begin
      retx_base <= 16'd200;
      tick_ms   <= 16'd50;
      max_tx    <= 8'd10;
      max_unack <= 16'd100;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_RETX_BASE: retx_base <= pwdata[15:0];
        REG_TICK:      tick_ms   <= pwdata[15:0];
        REG_MAX_TX:    max_tx    <= pwdata[7:0];
        REG_MAX_UNACK: max_unack <= pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_RETX_BASE: prdata = {16'd0, retx_base};
      REG_TICK:      prdata = {16'd0, tick_ms};
      REG_MAX_TX:    prdata = {24'd0, max_tx};
      REG_MAX_UNACK: prdata = {16'd0, max_unack};
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      q_op    <= s_tuser;
      q_seq   <= s_tdata[31:0];
      q_sgen  <= s_tdata[63:32];
      q_ack   <= s_tdata[95:64];
      q_agen  <= s_tdata[127:96];
      q_full  <= s_tdata[128];
      q_fresh <= s_tdata[160:129];
    end
    // Timeout threshold for the current transmit count.
    prod <= retx_base * cur.tc;
  end

  always_comb begin
    cur_next           = cur;
    cur_next.n         = 2'd0;
    cur_next.did_reset = 1'b0;
    cur_next.ack_ok    = 1'b0;
    was_empty          = 1'b0;
    moved              = 1'b0;
    verdict            = K_DISCARD;
    el_sum             = '0;
    case (q_op)
      OP_SEND: begin
        if (!cur_next.gl) begin
          cur_next.sg = q_fresh;
          cur_next.gl = 1'b1;
        end
        was_empty   = (cur_next.ar == cur_next.ss);
        cur_next.ss = next_seq(cur_next.ss);
        cur_next    = f_emit(cur_next, K_DATA, cur_next.ss, cur_next.sg, cur_next.rs,
                             cur_next.rg);
        cur_next.asent = cur_next.rs;
        if (was_empty) begin
          cur_next.el = '0;
          cur_next.tc = 8'd1;
        end
      end
      OP_RECV: begin
        if (!cur_next.gl) begin
          cur_next.sg = q_fresh;
          cur_next.gl = 1'b1;
        end
        if (q_ack != '0 && q_agen != cur_next.sg) begin
          verdict = K_DISCARD;
        end else if (q_sgen == ALL_ONES) begin
          if (q_agen == cur_next.sg) cur_next = f_forget(cur_next, q_fresh);
          verdict = K_DISCARD;
        end else if (cur_next.rg != q_sgen && q_seq != 32'd0 && q_seq != 32'd1) begin
          verdict = K_DISCARD;
        end else begin
          if (cur_next.rg != q_sgen) begin
            if (cur_next.rg != '0) cur_next = f_reset(cur_next, q_fresh);
            cur_next.rg = q_sgen;
          end
          // The generation may have been reloaded by a peer reset just above.
          if (q_ack != '0 && q_agen == cur_next.sg) begin
            cur_next.ack_ok = 1'b1;
            moved = (cur_next.ar != cur_next.ss) &&
                    in_window(q_ack, cur_next.ar, cur_next.ss);
            if (moved) cur_next.ar = q_ack;
            if (moved && cur_next.ar != cur_next.ss) begin
              cur_next.el = '0;
              if (cur_next.tc > 8'd1) begin
                cur_next.tc = 8'd1;
                cur_next    = f_resend(cur_next, q_fresh, max_tx);
              end
            end
          end
          if (q_seq == '0 || q_full) begin
            verdict = K_DISCARD;
          end else if (q_seq != next_seq(cur_next.rs)) begin
            cur_next = f_ack(cur_next, 1'b0);
            verdict  = K_DISCARD;
          end else begin
            cur_next.rs = q_seq;
            verdict     = K_DELIVER;
          end
        end
        cur_next = f_emit(cur_next, verdict, q_seq, q_sgen, '0, '0);
      end
      OP_TICK: begin
        if (cur_next.ar != cur_next.ss) begin
          el_sum      = {1'b0, cur_next.el} + {17'd0, tick_ms};
          cur_next.el = el_sum[32] ? ALL_ONES : el_sum[31:0];
          if (cur_next.el > {8'd0, prod}) cur_next = f_resend(cur_next, q_fresh, max_tx);
        end
        if (cur_next.asent != cur_next.rs) cur_next = f_ack(cur_next, 1'b0);
      end
      OP_HANGUP: begin
        if (cur_next.gl) begin
          cur_next = f_ack(cur_next, 1'b1);
          cur_next = f_forget(cur_next, q_fresh);
        end
      end
      default: begin
      end
    endcase
  end

  // Sequence distance from the last ack received to the last sequence sent.
  always_comb begin
    span         = cur.ss - cur.ar - {31'd0, (cur.ss < cur.ar)};
    unacked_next = (span[31:16] != '0) ? 16'hffff : span[15:0];
    waiting_next = waiting || ((q_op == OP_SEND) && (unacked_next > max_unack));
    resume_next  = waiting_next &&
                   (cur.did_reset || (cur.ack_ok && (unacked_next < (max_unack >> 3))));
    if (resume_next) waiting_next = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur     <= '0;
      waiting <= 1'b0;
      idx     <= '0;
    end else begin
      if (cmd.step) cur <= cur_next;
      if (cmd.fin) begin
        waiting <= waiting_next;
        idx     <= '0;
      end else if (cmd.pop) begin
        idx <= idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      unacked <= unacked_next;
      blocked <= unacked_next > max_unack;
      resume  <= resume_next;
    end
  end

  assign status.empty   = (cur.n == 2'd0);
  assign status.at_last = (idx == cur.n - 2'd1);

  assign m_tuser = cur.kind[idx];
  assign m_tlast = status.at_last;
  assign m_tdata = {6'd0, resume, blocked, unacked, cur.agen[idx], cur.ack[idx],
                    cur.gen[idx], cur.seq[idx]};

  `RDPE_ASSERT_NOW(a_idx_in_range, clk, rst, cmd.pop, idx < cur.n)
  `RDPE_ASSERT_NEXT(a_fin_clears_idx, clk, rst, cmd.fin, idx == 2'd0)
  `RDPE_ASSERT_NEXT(a_resume_clears_wait, clk, rst, cmd.fin && resume_next, !waiting)

endmodule

@@ rtl/core/reliable_datagram_peer_engine_core.sv @@
// Top level of the reliable-datagram peer sequencing engine.
`timescale 1ns / 1ps
// One event is taken per transfer on the s_ side and handled in a fixed sequence:
// capture, a load state, a step state that updates the peer state and fills a
// three-entry result buffer, and a state that settles the unacked count and flow-control
// flags. The event's results (0 to 3) then leave one per transfer, held while the m_ side
// stalls; the next event is accepted once the last result of the previous one has been
// transferred. Results of one event carry the same unacked count and flags; m_tlast marks
// the final one. An event that causes no result produces no transfer. The user must write
// registers through the APB port only while the engine is idle; the block does not enforce it.
module reliable_datagram_peer_engine_core
  import rdpe_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // pkt_seq, pkt_send_gen, pkt_ack, pkt_ack_gen, rx_queue_full, fresh_generation, pad
  input  logic [167:0] s_tdata,
  // op
  input  logic [1:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // seq_out, gen_out, ack_out, ack_gen_out, unacked_out, sender_blocked,
  // sender_may_resume, pad
  output logic [151:0] m_tdata,
  // kind
  output logic [2:0]   m_tuser,
  output logic         m_tlast,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  cmd_t    cmd;
  status_t status;

  assign pready = 1'b1;

  rdpe_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  rdpe_dp u_dp (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .status  (status),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tlast (m_tlast),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata)
  );

endmodule
